@@ sv/mvam_pkg.sv @@
// Package: shared types, constants and the sine table function for the voice mixer.
package mvam_pkg;

   localparam int NumVoices   = 16;
   localparam int SampleWords = 65536;
   localparam int SineEntries = 1024;
   localparam int VoiceBits   = $clog2(NumVoices);
   localparam int CountBits   = $clog2(NumVoices + 1);
   localparam int AddrBits    = $clog2(SampleWords);
   localparam int SineBits    = $clog2(SineEntries);

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SINE   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_WRITE  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_ALLOC,
      ST_VFETCH,
      ST_VCALC,
      ST_VMEM,
      ST_VACC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [23:0] phase_step;
      logic [23:0] speed;
      logic [15:0] sample_start;
      logic [16:0] sample_length;
      logic [15:0] mem_address;
      logic signed [15:0] mem_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic        out_channel;
      logic [3:0]  voice_index;
      logic        status;
   } rsp_type;

   // Divider control between sequencer and the shared divider.
   typedef struct packed {
      logic              load;
      logic signed [21:0] dividend;
      logic [CountBits-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic              done;
      logic signed [21:0] quotient;
   } div_sts_type;

   function automatic logic signed [15:0] sine_entry(input int i);
      longint q, quad, r, t, t2, m, y, s;
      q    = (longint'(i) << 18) / SineEntries;
      quad = (q >> 16) & 3;
      r    = q & 16'hFFFF;
      t    = quad[0] ? (65536 - r) : r;
      t2   = (t * t) >> 16;
      m    = 42047 - ((4640 * t2) >> 16);
      m    = 102944 - ((t2 * m) >> 16);
      y    = (t * m) >> 16;
      s    = (y * 32767 + 32768) >> 16;
      if (s > 32767) s = 32767;
      if (quad >= 2) s = -s;
      return s[15:0];
   endfunction

endpackage

@@ sv/mvam_divider.sv @@
// Shared restoring divider: signed sum over slot count, truncating toward zero.
module mvam_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mvam_pkg::div_ctl_type ctl,
   output mvam_pkg::div_sts_type sts
);
   import mvam_pkg::*;

   localparam int DW = 22;

   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CountBits-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DW:0]          trial;
   logic [DW-1:0]        shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DW-2:0], quo_ff[DW-1]};
      trial   = {1'b0, shifted} - {{(DW+1-CountBits){1'b0}}, den_ff};
      if (ctl.load) begin
         neg_in  = ctl.dividend[DW-1];
         quo_in  = ctl.dividend[DW-1] ? DW'(-ctl.dividend) : DW'(ctl.dividend);
         rem_in  = '0;
         den_in  = ctl.divisor;
         cnt_in  = 5'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule

@@ sv/mvam_sample_ram.sv @@
// Sample memory: one write port, one registered read port.
module mvam_sample_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [mvam_pkg::AddrBits-1:0] wr_addr,
   input  logic signed [15:0]            wr_data,
   input  logic [mvam_pkg::AddrBits-1:0] rd_addr,
   output logic signed [15:0]            rd_data
);
   import mvam_pkg::*;

   logic signed [15:0] mem [SampleWords];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/multi_voice_audio_mixer_unit.sv @@
// Top level: voice mixer with sequencer, voice registers, sample memory and divider.
//
// Voice mixer for up to 16 sine or sample-playback voices. Drive a word on
// req_word with start high while busy is low; the word is taken at that edge
// and busy rises. Every opcode except a sample-memory write returns exactly
// one rsp_word, flagged by rsp_valid for one cycle; the receiver cannot hold
// it off, so capture it when it appears. A memory write is written at the
// edge that takes it and passes through ST_DONE before busy falls again. A
// start walks the allocated slots for a finished one, then takes that slot or
// a new one, or flags status when none is free. A tick walks the allocated
// voices one at a time through a single adder (fetch, phase/offset add, sample
// memory read, accumulate), then hands the sum to the shared divider (load,
// 22 quotient bits, hand back). A tick with no allocated slot skips the
// divider. There is no clearing pass after reset: sample memory holds garbage
// until written, and reading a never-written word yields an undefined sample.
module multi_voice_audio_mixer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mvam_pkg::req_type req_word,
   output logic              rsp_valid,
   output mvam_pkg::rsp_type rsp_word
);
   import mvam_pkg::*;

   // sine table, filled once from the package polynomial, read registered
   logic signed [15:0] sine_rom [SineEntries];

   initial begin
      for (int i = 0; i < SineEntries; i++) sine_rom[i] = sine_entry(i);
   end

   // voice register file (per-slot flops, read by the voice pointer)
   logic        done_ff    [NumVoices];
   logic        is_sine_ff [NumVoices];
   logic [23:0] phase_ff   [NumVoices];
   logic [23:0] step_ff    [NumVoices];
   logic [31:0] pos_ff     [NumVoices];
   logic [15:0] base_ff    [NumVoices];
   logic [16:0] len_ff     [NumVoices];

   logic [CountBits-1:0] alloc_ff;
   logic                 chan_ff;
   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [CountBits-1:0] vp_ff, vp_in;
   logic signed [21:0]   acc_ff, acc_in;
   rsp_type              out_ff, out_in;
   logic                 outv_ff, outv_in;

   // per-voice working registers
   logic                 w_sine_ff;
   logic [23:0]          w_phase_ff;
   logic [23:0]          w_step_ff;
   logic [31:0]          w_pos_ff;
   logic [15:0]          w_base_ff;
   logic [16:0]          w_len_ff;
   logic [32:0]          sum_ff;
   logic                 w_hit_ff;
   logic signed [15:0]   sine_val_ff;

   logic [VoiceBits-1:0] vidx;
   logic                 found;
   logic [32:0]          adder_out;
   logic [15:0]          k16;
   logic                 hit;
   logic signed [15:0]   ram_rd;
   logic                 ram_we;
   div_ctl_type          dctl;
   div_sts_type          dsts;

   assign vidx = vp_ff[VoiceBits-1:0];

   // the single shared adder: phase + step, or position + speed
   assign adder_out = w_sine_ff ? {9'd0, w_phase_ff} + {9'd0, w_step_ff}
                                : {1'b0, w_pos_ff} + {9'd0, w_step_ff};
   assign k16 = sum_ff[31:16];
   assign hit = !sum_ff[32] && ({1'b0, k16} < w_len_ff);

   assign ram_we = (state_ff == ST_IDLE) && start && (req_word.opcode == OP_WRITE);

   mvam_sample_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_word.mem_address[AddrBits-1:0]),
      .wr_data (req_word.mem_value),
      .rd_addr (AddrBits'(w_base_ff + k16)),
      .rd_data (ram_rd)
   );

   // load the divider only when there is a slot count to divide by
   assign dctl.load     = (state_ff == ST_DIV) && (vp_ff == '0) && (alloc_ff != '0);
   assign dctl.dividend = acc_ff;
   assign dctl.divisor  = alloc_ff;

   mvam_divider u_div (.clock(clock), .reset(reset), .ctl(dctl), .sts(dsts));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_word.opcode)
                  OP_WRITE: state_in = ST_DONE;
                  OP_TICK:  state_in = ST_VFETCH;
                  default:  state_in = ST_FIND;
               endcase
            end
         end
         ST_FIND:   if (found || vp_ff >= alloc_ff) state_in = ST_ALLOC;
         ST_ALLOC:  state_in = ST_DONE;
         ST_VFETCH: state_in = (vp_ff >= alloc_ff) ? ST_DIV : ST_VCALC;
         ST_VCALC:  state_in = ST_VMEM;
         ST_VMEM:   state_in = ST_VACC;
         ST_VACC:   state_in = ST_VFETCH;
         ST_DIV:    if (alloc_ff == '0 || dsts.done) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign found = (state_ff == ST_FIND) && (vp_ff < alloc_ff) && done_ff[vidx];

   // datapath/outputs
   always_comb begin
      vp_in   = vp_ff;
      acc_in  = acc_ff;
      out_in  = out_ff;
      outv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            vp_in  = '0;
            acc_in = '0;
         end
         ST_FIND: if (!found && vp_ff < alloc_ff) vp_in = vp_ff + 1'b1;
         ST_ALLOC: begin
            out_in = '0;
            if (vp_ff >= CountBits'(NumVoices)) begin
               out_in.status = 1'b1;
            end else begin
               out_in.voice_index = 4'(vp_ff);
            end
            outv_in = 1'b1;
         end
         ST_VACC: begin
            if (!done_ff[vidx]) begin
               if (w_sine_ff) acc_in = acc_ff + 22'(sine_val_ff);
               else if (w_hit_ff) acc_in = acc_ff + 22'(ram_rd);
            end
            vp_in = vp_ff + 1'b1;
         end
         ST_VFETCH: if (vp_ff >= alloc_ff) vp_in = '0;
         ST_DIV: begin
            vp_in = CountBits'(1);
            if (alloc_ff == '0 || dsts.done) begin
               out_in = '0;
               out_in.out_channel = chan_ff;
               if (alloc_ff != '0) begin
                  if (dsts.quotient > 22'sd32767) out_in.mixed_sample = 16'sh7FFF;
                  else if (dsts.quotient < -22'sd32768) out_in.mixed_sample = 16'sh8000;
                  else out_in.mixed_sample = dsts.quotient[15:0];
               end
               outv_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         alloc_ff <= '0;
         chan_ff  <= 1'b0;
         outv_ff  <= 1'b0;
         vp_ff    <= '0;
         for (int i = 0; i < NumVoices; i++) begin
            done_ff[i]    <= 1'b1;
            is_sine_ff[i] <= 1'b0;
            phase_ff[i]   <= '0;
            step_ff[i]    <= '0;
            pos_ff[i]     <= '0;
            base_ff[i]    <= '0;
            len_ff[i]     <= '0;
         end
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         vp_ff    <= vp_in;
         if (state_ff == ST_IDLE && start) req_ff <= req_word;
         // take the finished slot found, or allocate a new slot when no finished one exists
         if (state_ff == ST_ALLOC && vp_ff < CountBits'(NumVoices)) begin
            if (vp_ff == alloc_ff) alloc_ff <= alloc_ff + 1'b1;
            done_ff[vidx] <= 1'b0;
            if (req_ff.opcode == OP_SINE) begin
               is_sine_ff[vidx] <= 1'b1;
               step_ff[vidx]    <= req_ff.phase_step;
               phase_ff[vidx]   <= '0;
            end else begin
               is_sine_ff[vidx] <= 1'b0;
               step_ff[vidx]    <= (req_ff.speed == '0) ? 24'h010000 : req_ff.speed;
               pos_ff[vidx]     <= '0;
               base_ff[vidx]    <= req_ff.sample_start;
               len_ff[vidx]     <= req_ff.sample_length;
            end
         end
         // write back the voice once its sum is registered; a sine phase advances only when chan_ff is set
         if (state_ff == ST_VMEM && !done_ff[vidx]) begin
            if (w_sine_ff) begin
               if (chan_ff) phase_ff[vidx] <= sum_ff[23:0];
            end else begin
               pos_ff[vidx] <= sum_ff[32] ? 32'hFFFF_FFFF : sum_ff[31:0];
               if (!hit) done_ff[vidx] <= 1'b1;
            end
         end
         if (state_ff == ST_DIV && state_in == ST_DONE) chan_ff <= !chan_ff;
      end
      acc_ff <= acc_in;
      out_ff <= out_in;
      if (state_ff == ST_VFETCH && vp_ff < alloc_ff) begin
         w_sine_ff  <= is_sine_ff[vidx];
         w_phase_ff <= phase_ff[vidx];
         w_step_ff  <= step_ff[vidx];
         w_pos_ff   <= pos_ff[vidx];
         w_base_ff  <= base_ff[vidx];
         w_len_ff   <= len_ff[vidx];
      end
      if (state_ff == ST_VCALC) begin
         sum_ff      <= adder_out;
         sine_val_ff <= sine_rom[w_phase_ff[23 -: SineBits]];
      end
      if (state_ff == ST_VMEM) w_hit_ff <= hit;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = outv_ff;
   assign rsp_word  = out_ff;
endmodule

@@ sv/mvam_checker.sv @@
// Port-level checker for the voice mixer, bound to the top level.
module mvam_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mvam_pkg::rsp_type rsp_word,
   input logic              rsp_valid
);
   import mvam_pkg::*;

   a_rsp_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status) |-> (rsp_word.voice_index == 4'd0 &&
       rsp_word.mixed_sample == 16'sd0)) else $error("bad full status");
endmodule

bind multi_voice_audio_mixer_unit mvam_checker u_mvam_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_word(rsp_word), .rsp_valid(rsp_valid)
);
